[rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the ARP binding spoof detector.
// No dependencies; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

[rtl/arpbsd_pkg.sv]
// Types and constants of the ARP binding spoof detector.
// No dependencies; imported by the binding cell and the top level.
`default_nettype none

package arpbsd_pkg;

    localparam int IP_W   = 32;
    localparam int MAC_W  = 48;
    localparam int OP_W   = 16;
    localparam int IDX_W  = 8;
    localparam int STAT_W = 3;

    localparam logic [OP_W-1:0] OP_REQUEST = 16'd1;
    localparam logic [OP_W-1:0] OP_REPLY   = 16'd2;

    typedef enum logic [STAT_W-1:0] {
        ST_IGNORED = 3'd0,
        ST_REFRESH = 3'd1,
        ST_SPOOF   = 3'd2,
        ST_NEW     = 3'd3,
        ST_FULL    = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_RESULT
    } fsm_t;

    // Search token handed from cell to cell.
    typedef struct packed {
        logic              valid;
        logic              found;
        logic              spoof;
        logic [MAC_W-1:0]  stored_mac;
        logic [IDX_W-1:0]  hit_idx;
    } tok_t;

endpackage

`default_nettype wire

[rtl/arp_binding_spoof_detector.sv]
// ARP binding spoof detector. Takes one parsed ARP message per input
// transaction (operation, sender IP, sender MAC) and returns one result
// transaction. Requests and replies are checked against a learned table of
// IP-to-MAC bindings held in a row of TABLE_DEPTH binding cells; a search
// token walks the row one cell per clock, so a request or reply stays in the
// search until its token leaves the last cell; the next message is accepted
// once the result is loaded into the output register. Any other operation
// code skips the cell row and goes straight to the result state. One
// message is in flight at a time; a new message is accepted while the
// previous result still waits in the output register. A matching IP with
// the same MAC reports a refresh, a matching IP with another MAC reports a
// spoof alert carrying the stored MAC (the table is left unchanged), an
// unknown IP is appended while room remains and is otherwise dropped as
// table full. entry_index gives the slot modulo 256. The table needs no
// clearing after reset: a slot counts only below the fill count.
// Depends on arpbsd_pkg, arpbsd_cell and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module arp_binding_spoof_detector
    import arpbsd_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [95:0] s_tdata,   // [15:0] arp_operation, [47:16] src_ip,
                                        // [95:48] src_mac
    // Result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata    // [2:0] status, [50:3] stored_mac,
                                        // [58:51] entry_index, [63:59] zero
);

    localparam int FILL_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [FILL_W-1:0] FULL_COUNT = FILL_W'(TABLE_DEPTH);

    // Unpack the input transaction.
    logic [OP_W-1:0]  in_op;
    logic [IP_W-1:0]  in_ip;
    logic [MAC_W-1:0] in_mac;

    assign in_op  = s_tdata[15:0];
    assign in_ip  = s_tdata[47:16];
    assign in_mac = s_tdata[95:48];

    // Control state
    fsm_t              state_reg;
    fsm_t              state_next;
    logic [FILL_W-1:0] fill_count_reg;
    logic [FILL_W-1:0] fill_count_next;
    logic              head_valid_reg;
    logic              ign_reg;
    logic              m_tvalid_reg;

    // Payload
    logic [IP_W-1:0]   q_ip_reg;
    logic [MAC_W-1:0]  q_mac_reg;
    tok_t              res_tok_reg;
    logic [63:0]       m_tdata_reg;

    logic    accept;
    logic    op_ok;
    logic    out_free;
    logic    load_out;
    logic    wr_en;
    logic    not_full;
    status_t res_status;
    logic [MAC_W-1:0] res_mac;
    logic [IDX_W-1:0] res_idx;

    tok_t chain [TABLE_DEPTH+1];

    assign op_ok    = (in_op == OP_REQUEST) || (in_op == OP_REPLY);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign not_full = fill_count_reg < FULL_COUNT;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            FSM_IDLE: begin
                if (s_tvalid) begin
                    state_next = op_ok ? FSM_SCAN : FSM_RESULT;
                end
            end
            FSM_SCAN: begin
                if (chain[TABLE_DEPTH].valid) begin
                    state_next = FSM_RESULT;
                end
            end
            FSM_RESULT: begin
                if (out_free) begin
                    state_next = FSM_IDLE;
                end
            end
            default: begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    // FSM outputs
    always_comb begin
        s_tready = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            FSM_IDLE: begin
                s_tready = 1'b1;
            end
            FSM_SCAN: begin
                s_tready = 1'b0;
            end
            FSM_RESULT: begin
                load_out = out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Resolve the result once the token has left the last cell.
    always_comb begin
        res_status = ST_IGNORED;
        res_mac    = '0;
        res_idx    = '0;
        wr_en      = 1'b0;
        if (ign_reg) begin
            res_status = ST_IGNORED;
        end else if (res_tok_reg.found) begin
            res_status = res_tok_reg.spoof ? ST_SPOOF : ST_REFRESH;
            res_mac    = res_tok_reg.stored_mac;
            res_idx    = res_tok_reg.hit_idx;
        end else if (not_full) begin
            res_status = ST_NEW;
            res_idx    = IDX_W'(fill_count_reg);
            wr_en      = load_out;
        end else begin
            res_status = ST_FULL;
        end
    end

    assign fill_count_next = wr_en ? fill_count_reg + 1'b1 : fill_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= FSM_IDLE;
            fill_count_reg <= '0;
            head_valid_reg <= 1'b0;
            ign_reg        <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            fill_count_reg <= fill_count_next;
            // Register the token launch alongside the query, so the token enters the row with the latched query.
            head_valid_reg <= accept && op_ok;
            if (accept) begin
                ign_reg <= !op_ok;
            end
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Hold the query for the cells; capture the token at the tail.
    always_ff @(posedge aclk) begin
        if (accept) begin
            q_ip_reg  <= in_ip;
            q_mac_reg <= in_mac;
        end
        if (chain[TABLE_DEPTH].valid) begin
            res_tok_reg <= chain[TABLE_DEPTH];
        end
        if (load_out) begin
            m_tdata_reg <= {5'b0, res_idx, res_mac, res_status};
        end
    end

    // Head of the cell row
    always_comb begin
        chain[0]       = '0;
        chain[0].valid = head_valid_reg;
    end

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        arpbsd_cell #(
            .TABLE_DEPTH (TABLE_DEPTH),
            .CELL_INDEX  (g)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .tok_in     (chain[g]),
            .query_ip   (q_ip_reg),
            .query_mac  (q_mac_reg),
            .fill_count (fill_count_reg),
            .wr_en      (wr_en),
            .tok_out    (chain[g+1])
        );
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // The fill count never runs past the table depth.
    `ASSERT_NEVER(a_fill_bound, aclk, aresetn, fill_count_reg > FULL_COUNT)
    // A token reaches the tail only while a search is under way.
    `ASSERT_PROP(a_tail_in_scan, aclk, aresetn, chain[TABLE_DEPTH].valid |-> state_reg == FSM_SCAN)
    // Every append is reported as a newly learned host.
    `ASSERT_PROP(a_wr_reports_new, aclk, aresetn, wr_en |=> m_tvalid_reg && m_tdata_reg[2:0] == ST_NEW)

endmodule

`default_nettype wire

[rtl/arpbsd_cell.sv]
// One binding cell: holds one IP-to-MAC entry and checks the passing token.
// Depends on arpbsd_pkg.
`default_nettype none

module arpbsd_cell
    import arpbsd_pkg::*;
#(
    parameter int TABLE_DEPTH = 256,
    parameter int CELL_INDEX  = 0,
    localparam int FILL_W     = $clog2(TABLE_DEPTH + 1)
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire tok_t              tok_in,
    input  wire logic [IP_W-1:0]   query_ip,
    input  wire logic [MAC_W-1:0]  query_mac,
    input  wire logic [FILL_W-1:0] fill_count,
    input  wire logic              wr_en,
    output tok_t                   tok_out
);

    localparam logic [FILL_W-1:0] MY_SLOT = FILL_W'(CELL_INDEX);

    logic [IP_W-1:0]  entry_ip_reg;
    logic [MAC_W-1:0] entry_mac_reg;
    tok_t             tok_reg;
    tok_t             tok_next;
    logic             live;
    logic             hit;
    logic             mac_diff;

    assign live     = MY_SLOT < fill_count;
    assign hit      = tok_in.valid && !tok_in.found && live && (entry_ip_reg == query_ip);
    assign mac_diff = entry_mac_reg != query_mac;

    always_comb begin
        tok_next = tok_in;
        if (hit) begin
            tok_next.found      = 1'b1;
            tok_next.spoof      = mac_diff;
            tok_next.stored_mac = mac_diff ? entry_mac_reg : '0;
            tok_next.hit_idx    = IDX_W'(CELL_INDEX);
        end
    end

    // Append: the slot equal to the fill count takes the new binding.
    always_ff @(posedge aclk) begin
        if (wr_en && (fill_count == MY_SLOT)) begin
            entry_ip_reg  <= query_ip;
            entry_mac_reg <= query_mac;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.valid <= 1'b0;
        end else begin
            tok_reg.valid <= tok_next.valid;
        end
        tok_reg.found      <= tok_next.found;
        tok_reg.spoof      <= tok_next.spoof;
        tok_reg.stored_mac <= tok_next.stored_mac;
        tok_reg.hit_idx    <= tok_next.hit_idx;
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire
